// File: design/fbc_pkg.sv
// Shared types and constants for the frustum box cull block.
package fbc_pkg;

    localparam int MAX_PLANES    = 6;
    localparam int PLANE_COUNT_D = 6;
    localparam int COORD_W       = 24;
    localparam int NORMAL_W      = 12;
    localparam int OFFSET_W      = 28;
    localparam int PROD_W        = COORD_W + NORMAL_W;
    localparam int DIST_W        = 40;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [CFG_IDX_W-1:0] REG_TEST_MODE = 3'd6;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] offset;
        logic signed [NORMAL_W-1:0] nz;
        logic signed [NORMAL_W-1:0] ny;
        logic signed [NORMAL_W-1:0] nx;
    } plane_t;

    // Per-plane partial products for one box: [0] uses min, [1] uses max.
    typedef struct packed {
        logic signed [1:0][PROD_W-1:0] px;
        logic signed [1:0][PROD_W-1:0] py;
        logic signed [1:0][PROD_W-1:0] pz;
    } prod_t;

endpackage

// File: design/frustum_box_cull.sv
// Top level of the frustum box cull block.
// One box is accepted per clock while the output is not stalled; its visible
// flag leaves through a four-stage pipeline (products, corner sums, sign test,
// plane OR). Each plane has its own multipliers, so throughput is one box per
// cycle when unstalled. A stalled output holds the pipeline without losing or repeating items.
module frustum_box_cull
    import fbc_pkg::*;
#(
    parameter int PLANE_COUNT = PLANE_COUNT_D
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [COORD_W-1:0]   s_box_min_x,
    input  logic signed [COORD_W-1:0]   s_box_min_y,
    input  logic signed [COORD_W-1:0]   s_box_min_z,
    input  logic signed [COORD_W-1:0]   s_box_max_x,
    input  logic signed [COORD_W-1:0]   s_box_max_y,
    input  logic signed [COORD_W-1:0]   s_box_max_z,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_visible,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);
    plane_t [MAX_PLANES-1:0] plane_reg;
    logic mode_reg;
    logic [3:0] vld_reg;
    logic [3:0] adv;
    logic [PLANE_COUNT-1:0] rej;
    logic vis_reg;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= '0;
            mode_reg  <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index < CFG_IDX_W'(MAX_PLANES))
                plane_reg[cfg_index] <= plane_t'(cfg_data);
            else if (cfg_index == REG_TEST_MODE)
                mode_reg <= cfg_data[0];
        end
    end

    // Stall control: a stage moves when the one after it is empty or moving
    always_comb begin
        adv[3] = !vld_reg[3] || m_ready;
        for (int i = 2; i >= 0; i--) adv[i] = !vld_reg[i] || adv[i+1];
    end
    assign s_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else begin
            if (adv[0]) vld_reg[0] <= s_valid;
            for (int i = 1; i < 4; i++) if (adv[i]) vld_reg[i] <= vld_reg[i-1];
        end
    end

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        fbc_plane_test u_test (
            .aclk(aclk), .adv(adv[2:0]), .plane(plane_reg[p]), .fast(mode_reg),
            .lo_x(s_box_min_x), .lo_y(s_box_min_y), .lo_z(s_box_min_z),
            .hi_x(s_box_max_x), .hi_y(s_box_max_y), .hi_z(s_box_max_z),
            .reject(rej[p])
        );
    end

    // Final stage: visible unless any plane rejects
    always_ff @(posedge aclk) begin
        if (adv[3]) vis_reg <= ~|rej;
    end

    assign m_valid   = vld_reg[3];
    assign m_visible = vis_reg;
endmodule

// File: design/fbc_plane_test.sv
// Pipelined rejection test of one box against one plane (three stages).
module fbc_plane_test
    import fbc_pkg::*;
(
    input  logic                       aclk,
    input  logic [2:0]                 adv,
    input  plane_t                     plane,
    input  logic                       fast,
    input  logic signed [COORD_W-1:0]  lo_x, lo_y, lo_z,
    input  logic signed [COORD_W-1:0]  hi_x, hi_y, hi_z,
    output logic                       reject
);
    prod_t prod_reg;
    logic signed [7:0][DIST_W-1:0] dist_reg;
    logic fast1_reg, fast2_reg;
    logic [2:0] pos1_reg, pos2_reg;
    logic reject_reg;
    logic signed [DIST_W-1:0] off_al;
    logic [7:0] neg;
    logic signed [DIST_W-1:0] pdist;
    logic [2:0] pv;

    // Stage 1: six products
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            prod_reg.px[0] <= plane.nx * lo_x;
            prod_reg.px[1] <= plane.nx * hi_x;
            prod_reg.py[0] <= plane.ny * lo_y;
            prod_reg.py[1] <= plane.ny * hi_y;
            prod_reg.pz[0] <= plane.nz * lo_z;
            prod_reg.pz[1] <= plane.nz * hi_z;
            fast1_reg <= fast;
            pos1_reg <= {plane.nz > 0, plane.ny > 0, plane.nx > 0};
        end
    end

    // Offset scaled to product units, sign kept
    assign off_al = DIST_W'(signed'({plane.offset, 10'd0}));

    // Stage 2: eight corner distances
    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            for (int c = 0; c < 8; c++) begin
                dist_reg[c] <= DIST_W'(signed'(prod_reg.px[c[0]]))
                             + DIST_W'(signed'(prod_reg.py[c[1]]))
                             + DIST_W'(signed'(prod_reg.pz[c[2]])) + off_al;
            end
            fast2_reg <= fast1_reg;
            pos2_reg  <= pos1_reg;
        end
    end

    // Stage 3: sign decision
    always_comb begin
        for (int c = 0; c < 8; c++) neg[c] = dist_reg[c][DIST_W-1];
        pv    = pos2_reg;
        pdist = dist_reg[pv];
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            reject_reg <= fast2_reg ? (pdist[DIST_W-1] || pdist == '0) : (&neg);
        end
    end

    assign reject = reject_reg;
endmodule

// File: design/fbc_checker.sv
// Port-level checker for the frustum box cull block, with its bind.
module fbc_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_visible
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_visible))
        else $error("result changed while stalled");
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output free");
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("item not delivered in four cycles");
    // With no input and the output free long enough to drain it, the pipeline is empty
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(s_valid) && !$past(s_valid,2) && !$past(s_valid,3) && !$past(s_valid,4)
        && $past(m_ready) && $past(m_ready,2) && $past(m_ready,3) && $past(m_ready,4)
        && $past(aresetn,4) |-> !m_valid)
        else $error("result without item");
endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_visible(m_visible)
);
